@@ sv/elot_pkg.sv @@
package elot_pkg;

	// Command selector codes; 6 and 7 are no-ops
	typedef enum logic [2:0] {
		FN_APPEND      = 3'd0,
		FN_REMOVE_IDX  = 3'd1,
		FN_REMOVE_LAST = 3'd2,
		FN_CLEAR       = 3'd3,
		FN_NEWEST      = 3'd4,
		FN_EXISTS      = 3'd5
	} func_t;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_NO_RECORD = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Record kinds; anything above insert acts as a delete
	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;

	// Operation broadcast to every cell of the chain
	typedef enum logic [2:0] {
		OP_IDLE    = 3'd0,
		OP_APPEND  = 3'd1,
		OP_FIND    = 3'd2,
		OP_REMOVE  = 3'd3,
		OP_COMPACT = 3'd4
	} cell_op_t;

	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] size;
		logic [63:0] data;
	} rec_t;

	// Token that walks the chain one cell per cycle
	typedef struct packed {
		logic vld;
		logic hit;
		rec_t rec;
	} scan_t;

	typedef struct packed {
		cell_op_t op;
		rec_t     rec;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [39:0] offset;
		logic [1:0]  action;
		logic [31:0] size_bytes;
		logic [63:0] data_word;
		logic [5:0]  entry_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [39:0] rec_offset;
		logic [1:0]  rec_action;
		logic [31:0] rec_size;
		logic [63:0] rec_data;
		logic [6:0]  entry_count;
	} result_t;

endpackage

@@ sv/elot_cell.sv @@
module elot_cell #(
	parameter int IDX = 0,
	parameter int OW  = 40,
	parameter int IW  = 6,
	parameter int CW  = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  elot_pkg::cell_ctl_t ctl,
	input  logic [OW-1:0]      pos,
	input  logic [IW-1:0]      sel,
	input  logic [CW-1:0]      count,
	input  elot_pkg::scan_t    scan_in,
	input  logic [OW-1:0]      scan_off_in,
	output elot_pkg::scan_t    scan_out,
	output logic [OW-1:0]      scan_off_out,
	input  logic [OW-1:0]      nxt_off,
	input  elot_pkg::rec_t     nxt_rec,
	output logic [OW-1:0]      off,
	output elot_pkg::rec_t     rec
);
	import elot_pkg::*;

	logic [OW-1:0] off_q;
	rec_t          rec_q;
	logic          vld_q;
	logic          hit_q;
	rec_t          srec_q;
	logic [OW-1:0] soff_q;

	logic [OW-1:0] off_d;
	rec_t          rec_d;
	scan_t         scan_d;
	logic [OW-1:0] soff_d;
	logic          is_sel;
	logic          is_live;
	logic          at_or_above;

	// Move an offset by one, holding it at either bound
	function automatic logic [OW-1:0] step_off(input logic [OW-1:0] v, input logic up);
		logic [OW-1:0] r;
		r = v;
		if (up) begin
			if (!(&v))
				r = v + OW'(1);
		end else begin
			if (v != '0)
				r = v - OW'(1);
		end
		return r;
	endfunction

	assign is_sel      = (sel == IW'(IDX));
	assign is_live     = (CW'(IDX) < count);
	assign at_or_above = (IW'(IDX) >= sel);

	// Decide the next entry and the token handed upward
	always_comb begin
		off_d  = off_q;
		rec_d  = rec_q;
		scan_d = scan_in;
		soff_d = scan_off_in;
		unique case (ctl.op)
			OP_APPEND: begin
				if (is_sel) begin
					off_d = pos;
					rec_d = ctl.rec;
				end else if (ctl.rec.act != ACT_UPDATE && off_q >= pos) begin
					off_d = step_off(off_q, ctl.rec.act == ACT_INSERT);
				end
			end
			OP_FIND: begin
				if (scan_in.vld && is_live && off_q == pos) begin
					scan_d.hit = 1'b1;
					scan_d.rec = rec_q;
					soff_d     = off_q;
				end
			end
			OP_REMOVE: begin
				if (scan_in.vld) begin
					if (is_sel) begin
						scan_d.hit = 1'b1;
						scan_d.rec = rec_q;
						soff_d     = off_q;
					end else if (scan_in.hit && scan_in.rec.act != ACT_UPDATE &&
							off_q >= scan_off_in) begin
						off_d = step_off(off_q, scan_in.rec.act != ACT_INSERT);
					end
				end
			end
			OP_COMPACT: begin
				if (at_or_above) begin
					off_d = nxt_off;
					rec_d = nxt_rec;
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		off_q  <= off_d;
		rec_q  <= rec_d;
		hit_q  <= scan_d.hit;
		srec_q <= scan_d.rec;
		soff_q <= soff_d;
	end

	// Advance the token marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= scan_d.vld;
		end
	end

	assign scan_out     = '{vld: vld_q, hit: hit_q, rec: srec_q};
	assign scan_off_out = soff_q;
	assign off          = off_q;
	assign rec          = rec_q;

endmodule

@@ sv/edit_log_offset_table.sv @@
// Edit log held in a chain of MAX_ENTRIES cells, one record per cell.
// Append, remove last, clear, unused codes and a bad remove index: the result strobe comes
// in the cycle after start. Remove at a valid index and both lookups: a token walks the chain
// one cell a cycle, and the strobe follows once it leaves the top cell; busy is high meanwhile.
// Busy is low in the strobe cycle, so the next command is accepted at the edge ending it.
// Reset empties the log; stored records are undefined until written; the receiver cannot stall.
module edit_log_offset_table #(
	parameter int MAX_ENTRIES  = 64,
	parameter int OFFSET_WIDTH = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  elot_pkg::cmd_t    cmd,
	output logic              done,
	output elot_pkg::result_t result
);
	import elot_pkg::*;

	localparam int OW   = OFFSET_WIDTH;
	localparam int IW   = $clog2(MAX_ENTRIES);
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > 6) ? CW : 6;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          launch_q, launch_d;
	logic [2:0]    fn_q;
	logic [OW-1:0] pos_q;
	logic [IW-1:0] ridx_q;
	logic          done_q, done_d;
	result_t       result_q, result_d;

	logic          accept;
	logic [OW-1:0] pos_in;
	logic          idx_ok;
	logic          last_vld;
	cell_ctl_t     ctl;
	logic [OW-1:0] pos_b;
	logic [IW-1:0] sel_b;

	scan_t         scan_w     [MAX_ENTRIES+1];
	logic [OW-1:0] scan_off_w [MAX_ENTRIES+1];
	logic [OW-1:0] off_w      [MAX_ENTRIES];
	rec_t          rec_w      [MAX_ENTRIES];
	logic [OW-1:0] nxt_off_w  [MAX_ENTRIES];
	rec_t          nxt_rec_w  [MAX_ENTRIES];

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign pos_in   = OW'(cmd.offset);
	assign idx_ok   = (CMPW'(cmd.entry_index) < CMPW'(count_q));
	assign last_vld = scan_w[MAX_ENTRIES].vld;

	// Broadcast the operation to the chain
	always_comb begin
		ctl.op  = OP_IDLE;
		ctl.rec = '{act: cmd.action, size: cmd.size_bytes, data: cmd.data_word};
		pos_b   = pos_in;
		sel_b   = IW'(count_q);
		if (state_q == S_SCAN) begin
			pos_b = pos_q;
			sel_b = ridx_q;
			if (fn_q == FN_REMOVE_IDX)
				ctl.op = last_vld ? OP_COMPACT : OP_REMOVE;
			else
				ctl.op = OP_FIND;
		end else if (accept && cmd.func == FN_APPEND && count_q < CW'(MAX_ENTRIES)) begin
			ctl.op = OP_APPEND;
		end
	end

	// Command control and result
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		launch_d = 1'b0;
		done_d   = 1'b0;
		result_d = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					done_d = 1'b1;
					case (cmd.func) inside
						FN_APPEND: begin
							if (count_q < CW'(MAX_ENTRIES))
								count_d = count_q + CW'(1);
							else
								result_d.status = ST_FULL;
						end
						FN_REMOVE_IDX: begin
							if (idx_ok) begin
								done_d   = 1'b0;
								launch_d = 1'b1;
								state_d  = S_SCAN;
							end else begin
								result_d.status = ST_BAD_INDEX;
							end
						end
						FN_REMOVE_LAST: begin
							if (count_q != '0)
								count_d = count_q - CW'(1);
							else
								result_d.status = ST_BAD_INDEX;
						end
						FN_CLEAR: begin
							count_d = '0;
						end
						FN_NEWEST, FN_EXISTS: begin
							done_d   = 1'b0;
							launch_d = 1'b1;
							state_d  = S_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (last_vld) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
					case (fn_q)
						FN_REMOVE_IDX: begin
							count_d = count_q - CW'(1);
						end
						FN_NEWEST: begin
							if (scan_w[MAX_ENTRIES].hit) begin
								result_d.found      = 1'b1;
								result_d.rec_offset = 40'(scan_off_w[MAX_ENTRIES]);
								result_d.rec_action = scan_w[MAX_ENTRIES].rec.act;
								result_d.rec_size   = scan_w[MAX_ENTRIES].rec.size;
								result_d.rec_data   = scan_w[MAX_ENTRIES].rec.data;
							end else begin
								result_d.status = ST_NO_RECORD;
							end
						end
						default: begin
							result_d.found = scan_w[MAX_ENTRIES].hit;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		result_d.entry_count = 7'(count_d);
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			launch_q <= launch_d;
			done_q   <= done_d;
		end
	end

	// Capture the command and the result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			fn_q   <= cmd.func;
			pos_q  <= pos_in;
			ridx_q <= IW'(cmd.entry_index);
		end
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

	// Feed the token into the bottom of the chain
	assign scan_w[0]     = '{vld: launch_q, hit: 1'b0, rec: '0};
	assign scan_off_w[0] = '0;

	// Build the chain
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i < MAX_ENTRIES - 1) begin : g_mid
			assign nxt_off_w[i] = off_w[i+1];
			assign nxt_rec_w[i] = rec_w[i+1];
		end else begin : g_top
			assign nxt_off_w[i] = off_w[i];
			assign nxt_rec_w[i] = rec_w[i];
		end

		elot_cell #(
			.IDX (i),
			.OW  (OW),
			.IW  (IW),
			.CW  (CW)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.pos          (pos_b),
			.sel          (sel_b),
			.count        (count_q),
			.scan_in      (scan_w[i]),
			.scan_off_in  (scan_off_w[i]),
			.scan_out     (scan_w[i+1]),
			.scan_off_out (scan_off_w[i+1]),
			.nxt_off      (nxt_off_w[i]),
			.nxt_rec      (nxt_rec_w[i]),
			.off          (off_w[i]),
			.rec          (rec_w[i])
		);
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import elot_pkg::*;

	localparam int DEPTH = 64;
	localparam int RANDOM_ITEMS = 1250;
	localparam int TAIL_CYCLES = 80;
	localparam int CYCLE_LIMIT = 600000;
	localparam int REPORT_MAX = 10;

	localparam logic [39:0] OFF_MAX = '1;
	localparam logic [5:0] IDX_TOP = '1;

	// Selector codes with no operation behind them
	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;

	// Record kinds beyond the package ones; the alias code acts as a delete
	localparam logic [1:0] ACT_DELETE = 2'd2;
	localparam logic [1:0] ACT_ALIAS_DEL = 2'd3;

	// Random traffic mixes
	localparam int MODE_FILL = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIX = 2;

	typedef struct {
		cmd_t    c;
		bit      typed;
		result_t res;
	} plan_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	// Shadow copy of the log
	logic [39:0] log_off  [DEPTH];
	logic [1:0]  log_act  [DEPTH];
	logic [31:0] log_size [DEPTH];
	logic [63:0] log_data [DEPTH];
	int          log_fill;

	result_t   awaited_results[$];
	result_t   want_res;
	plan_row_t plan[$];
	int        fail_count;
	int        cycle_count;

	edit_log_offset_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Move every stored offset from index first on that is at or above the pivot by one, clamped at both ends
	function automatic void shift_offsets(int first, logic [39:0] pivot, bit up);
		for (int i = first; i < log_fill; i++) begin
			if (log_off[i] >= pivot) begin
				if (up && log_off[i] != OFF_MAX)
					log_off[i] = log_off[i] + 40'd1;
				else if (!up && log_off[i] != '0)
					log_off[i] = log_off[i] - 40'd1;
			end
		end
	endfunction

	// Undo the record's shift on later records, then close the gap
	function automatic void drop_entry(int idx);
		logic [1:0] kind;
		kind = log_act[idx];
		if (kind != ACT_UPDATE)
			shift_offsets(idx + 1, log_off[idx], kind != ACT_INSERT);
		for (int i = idx; i + 1 < log_fill; i++) begin
			log_off[i]  = log_off[i + 1];
			log_act[i]  = log_act[i + 1];
			log_size[i] = log_size[i + 1];
			log_data[i] = log_data[i + 1];
		end
		log_fill--;
	endfunction

	// Apply one command to the shadow log and return the beat it should produce
	function automatic result_t apply_edit(cmd_t c);
		result_t r;
		r = '0;
		r.status = ST_OK;
		case (c.func)
			FN_APPEND: begin
				if (log_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (c.action != ACT_UPDATE)
						shift_offsets(0, c.offset, c.action == ACT_INSERT);
					log_off[log_fill]  = c.offset;
					log_act[log_fill]  = c.action;
					log_size[log_fill] = c.size_bytes;
					log_data[log_fill] = c.data_word;
					log_fill++;
				end
			end
			FN_REMOVE_IDX: begin
				if (int'(c.entry_index) < log_fill)
					drop_entry(int'(c.entry_index));
				else
					r.status = ST_BAD_INDEX;
			end
			FN_REMOVE_LAST: begin
				if (log_fill > 0)
					drop_entry(log_fill - 1);
				else
					r.status = ST_BAD_INDEX;
			end
			FN_CLEAR: begin
				log_fill = 0;
			end
			FN_NEWEST: begin
				r.status = ST_NO_RECORD;
				for (int i = log_fill - 1; i >= 0 && !r.found; i--) begin
					if (log_off[i] == c.offset) begin
						r.status     = ST_OK;
						r.found      = 1'b1;
						r.rec_offset = log_off[i];
						r.rec_action = log_act[i];
						r.rec_size   = log_size[i];
						r.rec_data   = log_data[i];
					end
				end
			end
			FN_EXISTS: begin
				for (int i = 0; i < log_fill && !r.found; i++)
					if (log_off[i] == c.offset)
						r.found = 1'b1;
			end
			default: ;
		endcase
		r.entry_count = 7'(log_fill);
		return r;
	endfunction

	function automatic cmd_t edit_cmd(logic [2:0] func, logic [39:0] offset,
			logic [1:0] action, logic [31:0] size_bytes, logic [63:0] data_word,
			logic [5:0] entry_index);
		cmd_t c;
		c.func        = func;
		c.offset      = offset;
		c.action      = action;
		c.size_bytes  = size_bytes;
		c.data_word   = data_word;
		c.entry_index = entry_index;
		return c;
	endfunction

	function automatic result_t res_of(logic [1:0] status, logic found, int count);
		result_t r;
		r = '0;
		r.status      = status;
		r.found       = found;
		r.entry_count = 7'(count);
		return r;
	endfunction

	task automatic add_row(cmd_t c, bit typed, result_t res);
		plan_row_t row;
		row.c     = c;
		row.typed = typed;
		row.res   = res;
		plan.push_back(row);
	endtask

	// Positions clustered near both ends and on stored records, so lookups hit
	function automatic logic [39:0] pick_offset();
		int sel;
		sel = $urandom_range(0, 5);
		case (sel)
			0: return 40'($urandom_range(0, 15));
			1: return OFF_MAX - 40'($urandom_range(0, 15));
			2: return {8'($urandom_range(0, 255)), 32'($urandom)};
			default: begin
				if (log_fill == 0)
					return 40'($urandom_range(0, 15));
				return log_off[$urandom_range(0, log_fill - 1)]
					+ 40'($urandom_range(0, 2)) - 40'd1;
			end
		endcase
	endfunction

	function automatic cmd_t next_edit(int mode);
		cmd_t c;
		int   roll;
		c.offset     = pick_offset();
		c.action     = 2'($urandom_range(0, 3));
		c.size_bytes = $urandom;
		c.data_word  = {$urandom, $urandom};
		if (log_fill > 0 && $urandom_range(0, 3) != 0)
			c.entry_index = 6'($urandom_range(0, log_fill - 1));
		else
			c.entry_index = 6'($urandom_range(0, 63));
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				if (roll < 88)      c.func = FN_APPEND;
				else if (roll < 93) c.func = FN_NEWEST;
				else if (roll < 97) c.func = FN_EXISTS;
				else                c.func = FN_REMOVE_LAST;
			end
			MODE_DRAIN: begin
				if (roll < 30)      c.func = FN_REMOVE_IDX;
				else if (roll < 55) c.func = FN_REMOVE_LAST;
				else if (roll < 72) c.func = FN_NEWEST;
				else if (roll < 88) c.func = FN_EXISTS;
				else if (roll < 97) c.func = FN_APPEND;
				else                c.func = FN_CLEAR;
			end
			default: begin
				if (roll < 35)      c.func = FN_APPEND;
				else if (roll < 50) c.func = FN_REMOVE_IDX;
				else if (roll < 58) c.func = FN_REMOVE_LAST;
				else if (roll < 75) c.func = FN_NEWEST;
				else if (roll < 92) c.func = FN_EXISTS;
				else if (roll < 95) c.func = FN_CLEAR;
				else                c.func = $urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7;
			end
		endcase
		return c;
	endfunction

	// Present one command, hold it until accepted, then log what it should return
	task automatic issue(cmd_t c, bit typed, result_t typed_res);
		result_t r;
		cmd   <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = apply_edit(c);
		awaited_results.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	task automatic hold_off(int cycles);
		start <= 1'b0;
		repeat (cycles)
			@(negedge clk);
	endtask

	// Hold the sender until every outstanding beat has come back
	task automatic drain_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (awaited_results.size() != 0);
	endtask

	// Compare each result beat with the oldest outstanding one
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (awaited_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected result beat at cycle %0d: %p", cycle_count, result);
			end else begin
				want_res = awaited_results.pop_front();
				if (result.status !== want_res.status || result.found !== want_res.found
						|| result.rec_offset !== want_res.rec_offset
						|| result.rec_action !== want_res.rec_action
						|| result.rec_size !== want_res.rec_size
						|| result.rec_data !== want_res.rec_data
						|| result.entry_count !== want_res.entry_count) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("mismatch at cycle %0d", cycle_count);
						$display("  exp status=%0d found=%0d off=%h act=%0d size=%h data=%h cnt=%0d",
							want_res.status, want_res.found, want_res.rec_offset,
							want_res.rec_action, want_res.rec_size, want_res.rec_data,
							want_res.entry_count);
						$display("  got status=%0d found=%0d off=%h act=%0d size=%h data=%h cnt=%0d",
							result.status, result.found, result.rec_offset,
							result.rec_action, result.rec_size, result.rec_data,
							result.entry_count);
					end
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		int mode;
		int span;
		int burst_left;
		int random_sent;

		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		fail_count  = 0;
		cycle_count = 0;
		log_fill    = 0;
		burst_left  = $urandom_range(1, 40);
		random_sent = 0;

		// Empty log: removes fail, lookups miss, spare codes do nothing
		add_row(edit_cmd(FN_REMOVE_LAST, '0, ACT_UPDATE, '0, '0, '0), 1,
			res_of(ST_BAD_INDEX, 0, 0));
		add_row(edit_cmd(FN_REMOVE_IDX, '0, ACT_UPDATE, '0, '0, IDX_TOP), 1,
			res_of(ST_BAD_INDEX, 0, 0));
		add_row(edit_cmd(FN_NEWEST, '0, ACT_UPDATE, '0, '0, '0), 1,
			res_of(ST_NO_RECORD, 0, 0));
		add_row(edit_cmd(FN_EXISTS, OFF_MAX, ACT_UPDATE, '0, '0, '0), 1,
			res_of(ST_OK, 0, 0));
		add_row(edit_cmd(FN_SPARE6, '0, ACT_UPDATE, '0, '0, '0), 1, res_of(ST_OK, 0, 0));
		add_row(edit_cmd(FN_SPARE7, OFF_MAX, ACT_ALIAS_DEL, '1, '1, IDX_TOP), 1,
			res_of(ST_OK, 0, 0));
		// Appends of every kind at both ends, saturating up and down
		add_row(edit_cmd(FN_APPEND, '0, ACT_UPDATE, '1, '1, '0), 1, res_of(ST_OK, 0, 1));
		add_row(edit_cmd(FN_APPEND, '0, ACT_INSERT, '0, '0, '0), 1, res_of(ST_OK, 0, 2));
		add_row(edit_cmd(FN_APPEND, OFF_MAX, ACT_DELETE, 32'h1234_5678,
			64'h0123_4567_89ab_cdef, '0), 1, res_of(ST_OK, 0, 3));
		add_row(edit_cmd(FN_APPEND, OFF_MAX, ACT_INSERT, 32'h8000_0000,
			64'h8000_0000_0000_0001, '0), 1, res_of(ST_OK, 0, 4));
		add_row(edit_cmd(FN_APPEND, '0, ACT_ALIAS_DEL, 32'h0000_0001,
			64'hfedc_ba98_7654_3210, '0), 1, res_of(ST_OK, 0, 5));
		// Lookups on the shifted records
		add_row(edit_cmd(FN_NEWEST, '0, ACT_UPDATE, '0, '0, '0), 0, '0);
		add_row(edit_cmd(FN_NEWEST, OFF_MAX - 40'd1, ACT_UPDATE, '0, '0, '0), 0, '0);
		add_row(edit_cmd(FN_EXISTS, 40'd1, ACT_UPDATE, '0, '0, '0), 0, '0);
		add_row(edit_cmd(FN_NEWEST, 40'd5, ACT_UPDATE, '0, '0, '0), 0, '0);
		// Removals undo their shifts; an index past the fill fails
		add_row(edit_cmd(FN_REMOVE_IDX, '0, ACT_UPDATE, '0, '0, 6'd1), 0, '0);
		add_row(edit_cmd(FN_REMOVE_IDX, '0, ACT_UPDATE, '0, '0, 6'd4), 1,
			res_of(ST_BAD_INDEX, 0, 4));
		add_row(edit_cmd(FN_REMOVE_IDX, '0, ACT_UPDATE, '0, '0, 6'd3), 0, '0);
		add_row(edit_cmd(FN_NEWEST, OFF_MAX - 40'd2, ACT_UPDATE, '0, '0, '0), 0, '0);
		add_row(edit_cmd(FN_REMOVE_LAST, '0, ACT_UPDATE, '0, '0, '0), 0, '0);
		add_row(edit_cmd(FN_REMOVE_IDX, '0, ACT_UPDATE, '0, '0, '0), 0, '0);
		// Clear, then start over
		add_row(edit_cmd(FN_CLEAR, '0, ACT_UPDATE, '0, '0, '0), 1, res_of(ST_OK, 0, 0));
		add_row(edit_cmd(FN_EXISTS, '0, ACT_UPDATE, '0, '0, '0), 1, res_of(ST_OK, 0, 0));
		add_row(edit_cmd(FN_APPEND, OFF_MAX, ACT_UPDATE, $urandom, {$urandom, $urandom}, '0),
			1, res_of(ST_OK, 0, 1));
		add_row(edit_cmd(FN_NEWEST, OFF_MAX, ACT_UPDATE, '0, '0, '0), 0, '0);

		repeat (12)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		foreach (plan[i])
			issue(plan[i].c, plan[i].typed, plan[i].res);
		drain_results();

		// Random episodes that fill, drain or mix, sent in bursts
		while (random_sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 3);
			if (mode > MODE_MIX)
				mode = MODE_MIX;
			span = $urandom_range(8, 80);
			for (int k = 0; k < span && random_sent < RANDOM_ITEMS; k++) begin
				issue(next_edit(mode), 1'b0, '0);
				random_sent++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					hold_off($urandom_range(1, 12));
				end
			end
			if ($urandom_range(0, 5) == 0)
				drain_results();
		end

		drain_results();
		repeat (TAIL_CYCLES)
			@(negedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
